[rtl/etfp_pkg.sv]
package etfp_pkg;

    localparam int WIDTH  = 600;
    localparam int HEIGHT = 600;

    localparam int PIX_W     = 10;
    localparam int FRAC_BITS = 20;
    localparam int SEED_W    = 22;
    localparam int GAIN_W    = 9;
    localparam int COLOR_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_COUNT = 20;
    localparam int N_ITER    = MAX_COUNT + 1;
    localparam int N_W       = $clog2(N_ITER + 1);

    localparam int C_RE_OFFSET = 1363149;
    localparam int C_IM_OFFSET = 524288;
    localparam longint ESCAPE_Q40 = 64'sd2473901162496;

    localparam int SEED_RESET = -104858;
    localparam int GAIN_RESET = 63;
    localparam int GAIN_LIMIT = 256;

    localparam int RECIP_W = 32;
    localparam int PROD_W  = PIX_W + RECIP_W;
    localparam int X_LOG   = $clog2(WIDTH);
    localparam int Y_LOG   = $clog2(HEIGHT);
    localparam int X_SHIFT = PIX_W + X_LOG;
    localparam int Y_SHIFT = PIX_W + Y_LOG;
    localparam longint unsigned X_RECIP_L =
        ((64'd1 << (PIX_W + FRAC_BITS + X_LOG)) + 64'(WIDTH) - 64'd1) / 64'(WIDTH);
    localparam longint unsigned Y_RECIP_L =
        ((64'd1 << (PIX_W + FRAC_BITS + Y_LOG)) + 64'(HEIGHT) - 64'd1) / 64'(HEIGHT);
    localparam logic [RECIP_W-1:0] X_RECIP = RECIP_W'(X_RECIP_L);
    localparam logic [RECIP_W-1:0] Y_RECIP = RECIP_W'(Y_RECIP_L);

    localparam int MIN_DIM = (WIDTH < HEIGHT) ? WIDTH : HEIGHT;
    localparam longint unsigned Q_MAX =
        (((64'd1 << PIX_W) - 64'd1) << FRAC_BITS) / 64'(MIN_DIM);
    localparam int Q_W   = $clog2(Q_MAX + 64'd1);
    localparam int OFS_W = $clog2(((C_RE_OFFSET > C_IM_OFFSET) ? C_RE_OFFSET : C_IM_OFFSET) + 1);
    localparam int C_W   = ((Q_W > OFS_W) ? Q_W : OFS_W) + 1;
    localparam int STEP_W = FRAC_BITS + 3;
    localparam int Z_W    = ((C_W > STEP_W) ? C_W : STEP_W) + 1;
    localparam int SQ_W   = 2 * Z_W;
    localparam int MAG_W  = SQ_W + 1;

    typedef logic [PIX_W-1:0]          t_pix;
    typedef logic [PROD_W-1:0]         t_recip_prod;
    typedef logic [Q_W-1:0]            t_quot;
    typedef logic signed [SEED_W-1:0]  t_seed;
    typedef logic [GAIN_W-1:0]         t_gain;
    typedef logic [COLOR_W-1:0]        t_color;
    typedef logic [GAIN_W+COLOR_W-1:0] t_blue_prod;
    typedef logic signed [C_W-1:0]     t_coef;
    typedef logic signed [STEP_W-1:0]  t_step;
    typedef logic signed [Z_W-1:0]     t_z;
    typedef logic signed [SQ_W-1:0]    t_sq;
    typedef logic signed [MAG_W-1:0]   t_mag;
    typedef logic [N_W-1:0]            t_count;

    typedef struct packed {
        t_pix   px;
        t_pix   py;
        t_coef  cre;
        t_coef  cim;
        t_z     re;
        t_z     im;
        t_count n;
        logic   done;
    } t_iter;

    typedef struct packed {
        t_pix   px;
        t_pix   py;
        t_coef  cre;
        t_coef  cim;
        t_count n;
        logic   done;
        t_sq    rr;
        t_sq    ii;
        t_sq    ri;
    } t_prod;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_REAL = 2'd0,
        CFG_SEED_IMAG = 2'd1,
        CFG_BLUE_GAIN = 2'd2
    } t_cfg_index;

    typedef t_color t_red_lut [0:(1 << N_W) - 1];

    function automatic t_red_lut red_lut_build();
        t_red_lut lut;
        for (int i = 0; i < (1 << N_W); i++) begin
            if (i < MAX_COUNT) begin
                lut[i] = COLOR_W'((255 * i * i) / 400);
            end else begin
                lut[i] = '0;
            end
        end
        return lut;
    endfunction

    localparam t_red_lut RED_LUT = red_lut_build();

endpackage

[rtl/escape_time_fractal_pixel.sv]
// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_stall          i_pixel_x, i_pixel_y
// output    out        o_valid / i_stall          o_out_x, o_out_y, o_red, o_blue
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel enters per cycle while the output is not stalled.
// The depth is two stages for the coordinate scaling, two stages for each of
// the 21 unrolled iteration units (squares, then escape test and update), and
// two stages for the red lookup and the blue scaling.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults. A stall while the output is valid freezes the whole pipeline.
module escape_time_fractal_pixel (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [etfp_pkg::PIX_W-1:0]       i_pixel_x,
    input  logic [etfp_pkg::PIX_W-1:0]       i_pixel_y,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [etfp_pkg::PIX_W-1:0]       o_out_x,
    output logic [etfp_pkg::PIX_W-1:0]       o_out_y,
    output logic [etfp_pkg::COLOR_W-1:0]     o_red,
    output logic [etfp_pkg::COLOR_W-1:0]     o_blue,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [etfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [etfp_pkg::SEED_W-1:0]      i_cfg_data
);

    etfp_pkg::t_seed r_seed_real;
    etfp_pkg::t_seed r_seed_imag;
    etfp_pkg::t_gain r_blue_gain;

    logic adv;

    logic                     r_e_valid;
    etfp_pkg::t_pix           r_e_px;
    etfp_pkg::t_pix           r_e_py;
    etfp_pkg::t_recip_prod    r_e_xp;
    etfp_pkg::t_recip_prod    r_e_yp;

    logic            r_it_valid [0:etfp_pkg::N_ITER];
    etfp_pkg::t_iter r_it       [0:etfp_pkg::N_ITER];
    logic            r_pr_valid [0:etfp_pkg::N_ITER-1];
    etfp_pkg::t_prod r_pr       [0:etfp_pkg::N_ITER-1];

    etfp_pkg::t_quot qx;
    etfp_pkg::t_quot qy;
    etfp_pkg::t_iter n_start;

    logic             r_rd_valid;
    etfp_pkg::t_pix   r_rd_px;
    etfp_pkg::t_pix   r_rd_py;
    etfp_pkg::t_color r_rd_red;

    etfp_pkg::t_gain      gain_sat;
    etfp_pkg::t_blue_prod blue_prod;

    logic             r_out_valid;
    etfp_pkg::t_pix   r_out_x;
    etfp_pkg::t_pix   r_out_y;
    etfp_pkg::t_color r_out_red;
    etfp_pkg::t_color r_out_blue;

    assign adv         = !r_out_valid || !i_stall;
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_real <= etfp_pkg::t_seed'(etfp_pkg::SEED_RESET);
            r_seed_imag <= etfp_pkg::t_seed'(etfp_pkg::SEED_RESET);
            r_blue_gain <= etfp_pkg::t_gain'(etfp_pkg::GAIN_RESET);
        end else if (i_cfg_valid) begin
            case (etfp_pkg::t_cfg_index'(i_cfg_index))
                etfp_pkg::CFG_SEED_REAL: r_seed_real <= etfp_pkg::t_seed'(i_cfg_data);
                etfp_pkg::CFG_SEED_IMAG: r_seed_imag <= etfp_pkg::t_seed'(i_cfg_data);
                etfp_pkg::CFG_BLUE_GAIN: r_blue_gain <= i_cfg_data[etfp_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Scale the pixel coordinates by multiplying with a rounded-up reciprocal.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (adv) begin
            r_e_valid <= i_valid;
        end
        if (adv) begin
            r_e_px <= i_pixel_x;
            r_e_py <= i_pixel_y;
            r_e_xp <= etfp_pkg::t_recip_prod'(i_pixel_x)
                    * etfp_pkg::t_recip_prod'(etfp_pkg::X_RECIP);
            r_e_yp <= etfp_pkg::t_recip_prod'(i_pixel_y)
                    * etfp_pkg::t_recip_prod'(etfp_pkg::Y_RECIP);
        end
    end

    always_comb begin
        qx = r_e_xp[etfp_pkg::X_SHIFT +: etfp_pkg::Q_W];
        qy = r_e_yp[etfp_pkg::Y_SHIFT +: etfp_pkg::Q_W];
        n_start.px   = r_e_px;
        n_start.py   = r_e_py;
        n_start.cre  = etfp_pkg::t_coef'(qx) - etfp_pkg::t_coef'(etfp_pkg::C_RE_OFFSET);
        n_start.cim  = etfp_pkg::t_coef'(qy) - etfp_pkg::t_coef'(etfp_pkg::C_IM_OFFSET);
        n_start.re   = etfp_pkg::t_z'(r_seed_real);
        n_start.im   = etfp_pkg::t_z'(r_seed_imag);
        n_start.n    = '0;
        n_start.done = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_valid[0] <= 1'b0;
        end else if (adv) begin
            r_it_valid[0] <= r_e_valid;
        end
        if (adv) begin
            r_it[0] <= n_start;
        end
    end

    for (genvar k = 0; k < etfp_pkg::N_ITER; k++) begin : g_iter
        etfp_pkg::t_prod n_prod;
        etfp_pkg::t_iter n_next;
        etfp_pkg::t_mag  mag;
        etfp_pkg::t_sq   diff;
        etfp_pkg::t_step step_re;
        etfp_pkg::t_step step_im;
        logic            escaped;

        always_comb begin
            n_prod.px   = r_it[k].px;
            n_prod.py   = r_it[k].py;
            n_prod.cre  = r_it[k].cre;
            n_prod.cim  = r_it[k].cim;
            n_prod.n    = r_it[k].n;
            n_prod.done = r_it[k].done;
            n_prod.rr   = etfp_pkg::t_sq'(r_it[k].re) * etfp_pkg::t_sq'(r_it[k].re);
            n_prod.ii   = etfp_pkg::t_sq'(r_it[k].im) * etfp_pkg::t_sq'(r_it[k].im);
            n_prod.ri   = etfp_pkg::t_sq'(r_it[k].re) * etfp_pkg::t_sq'(r_it[k].im);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pr_valid[k] <= 1'b0;
            end else if (adv) begin
                r_pr_valid[k] <= r_it_valid[k];
            end
            if (adv) begin
                r_pr[k] <= n_prod;
            end
        end

        // Both shifts floor toward minus infinity; the doubled cross term
        // shifts one place less instead of being doubled.
        always_comb begin
            mag     = etfp_pkg::t_mag'(r_pr[k].rr) + etfp_pkg::t_mag'(r_pr[k].ii);
            escaped = mag >= etfp_pkg::t_mag'(etfp_pkg::ESCAPE_Q40);
            diff    = r_pr[k].rr - r_pr[k].ii;
            step_re = diff[etfp_pkg::FRAC_BITS +: etfp_pkg::STEP_W];
            step_im = r_pr[k].ri[etfp_pkg::FRAC_BITS-1 +: etfp_pkg::STEP_W];
            n_next.px   = r_pr[k].px;
            n_next.py   = r_pr[k].py;
            n_next.cre  = r_pr[k].cre;
            n_next.cim  = r_pr[k].cim;
            n_next.re   = etfp_pkg::t_z'(step_re) + etfp_pkg::t_z'(r_pr[k].cre);
            n_next.im   = etfp_pkg::t_z'(step_im) + etfp_pkg::t_z'(r_pr[k].cim);
            n_next.n    = r_pr[k].n;
            n_next.done = r_pr[k].done;
            if (!r_pr[k].done) begin
                if (escaped) begin
                    n_next.done = 1'b1;
                end else begin
                    n_next.n = r_pr[k].n + etfp_pkg::t_count'(1);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_it_valid[k+1] <= 1'b0;
            end else if (adv) begin
                r_it_valid[k+1] <= r_pr_valid[k];
            end
            if (adv) begin
                r_it[k+1] <= n_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (adv) begin
            r_rd_valid <= r_it_valid[etfp_pkg::N_ITER];
        end
        if (adv) begin
            r_rd_px  <= r_it[etfp_pkg::N_ITER].px;
            r_rd_py  <= r_it[etfp_pkg::N_ITER].py;
            r_rd_red <= etfp_pkg::RED_LUT[r_it[etfp_pkg::N_ITER].n];
        end
    end

    always_comb begin
        gain_sat = (r_blue_gain > etfp_pkg::t_gain'(etfp_pkg::GAIN_LIMIT))
                 ? etfp_pkg::t_gain'(etfp_pkg::GAIN_LIMIT) : r_blue_gain;
        blue_prod = etfp_pkg::t_blue_prod'(gain_sat) * etfp_pkg::t_blue_prod'(r_rd_red);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_rd_valid;
        end
        if (adv) begin
            r_out_x    <= r_rd_px;
            r_out_y    <= r_rd_py;
            r_out_red  <= r_rd_red;
            r_out_blue <= blue_prod[etfp_pkg::COLOR_W +: etfp_pkg::COLOR_W];
        end
    end

    assign o_valid = r_out_valid;
    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;
    assign o_red   = r_out_red;
    assign o_blue  = r_out_blue;

endmodule

[tb/sv/escape_time_fractal_pixel_tb.sv]
`timescale 1ns / 100ps

module escape_time_fractal_pixel_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int REPORT_CAP     = 100;
    localparam logic [etfp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef logic [etfp_pkg::SEED_W-1:0] t_cfg_word;

    typedef struct {
        etfp_pkg::t_pix   x;
        etfp_pkg::t_pix   y;
        etfp_pkg::t_color red;
        etfp_pkg::t_color blue;
    } t_pixel_color;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [etfp_pkg::PIX_W-1:0]     i_pixel_x;
    logic [etfp_pkg::PIX_W-1:0]     i_pixel_y;
    logic                           o_valid;
    logic                           i_stall;
    logic [etfp_pkg::PIX_W-1:0]     o_out_x;
    logic [etfp_pkg::PIX_W-1:0]     o_out_y;
    logic [etfp_pkg::COLOR_W-1:0]   o_red;
    logic [etfp_pkg::COLOR_W-1:0]   o_blue;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [etfp_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [etfp_pkg::SEED_W-1:0]    i_cfg_data;

    t_pixel_color expected_pixels[$];
    longint       seed_re_q20;
    longint       seed_im_q20;
    int           blue_gain_reg;
    int           mismatch_count;
    int           quiet_cycles;
    int           hold_left;
    int           stall_left;
    bit           src_idle_on;
    bit           sink_idle_on;

    escape_time_fractal_pixel DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_red       (o_red),
        .o_blue      (o_blue),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic t_pixel_color fractal_color(input etfp_pkg::t_pix px,
                                                   input etfp_pkg::t_pix py);
        t_pixel_color res;
        longint lx;
        longint ly;
        longint cre;
        longint cim;
        longint re;
        longint im;
        longint rr;
        longint ii;
        longint ri;
        int     n;
        int     red;
        int     gain;
        bit     escaped;
        lx = longint'(px);
        ly = longint'(py);
        cre = ((lx << etfp_pkg::FRAC_BITS) / longint'(etfp_pkg::WIDTH))
            - longint'(etfp_pkg::C_RE_OFFSET);
        cim = ((ly << etfp_pkg::FRAC_BITS) / longint'(etfp_pkg::HEIGHT))
            - longint'(etfp_pkg::C_IM_OFFSET);
        re = seed_re_q20;
        im = seed_im_q20;
        n = 0;
        escaped = 1'b0;
        while (n <= etfp_pkg::MAX_COUNT && !escaped) begin
            rr = re * re;
            ii = im * im;
            if (rr + ii >= etfp_pkg::ESCAPE_Q40) begin
                escaped = 1'b1;
            end else begin
                ri = re * im;
                re = ((rr - ii) >>> etfp_pkg::FRAC_BITS) + cre;
                im = ((longint'(2) * ri) >>> etfp_pkg::FRAC_BITS) + cim;
                n++;
            end
        end
        red = (n < etfp_pkg::MAX_COUNT) ? (255 * n * n) / 400 : 0;
        gain = (blue_gain_reg > etfp_pkg::GAIN_LIMIT) ? etfp_pkg::GAIN_LIMIT : blue_gain_reg;
        res.x = px;
        res.y = py;
        res.red = etfp_pkg::t_color'(red);
        res.blue = etfp_pkg::t_color'((gain * red) >> 8);
        return res;
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic etfp_pkg::t_pix random_pixel();
        if ($urandom_range(0, 7) == 0) begin
            return etfp_pkg::t_pix'($urandom_range(0, 1023));
        end
        return etfp_pkg::t_pix'($urandom_range(0, 599));
    endfunction

    function automatic t_cfg_word random_seed();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) begin
            return t_cfg_word'($urandom());
        end else if (r == 1) begin
            return t_cfg_word'($urandom_range(0, 629146) - 314573);
        end
        return t_cfg_word'($urandom_range(0, 3145728) - 1572864);
    endfunction

    function automatic t_cfg_word random_gain_word();
        t_cfg_word word;
        int r;
        word = t_cfg_word'($urandom());
        r = $urandom_range(0, 5);
        if (r == 0) begin
            word[etfp_pkg::GAIN_W-1:0] = '0;
        end else if (r == 1) begin
            word[etfp_pkg::GAIN_W-1:0] = etfp_pkg::t_gain'(etfp_pkg::GAIN_LIMIT);
        end else if (r == 2) begin
            word[etfp_pkg::GAIN_W-1:0] = '1;
        end else begin
            word[etfp_pkg::GAIN_W-1:0] = etfp_pkg::t_gain'($urandom_range(0, 511));
        end
        return word;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic write_register(input logic [etfp_pkg::CFG_IDX_W-1:0] idx,
                                  input t_cfg_word data);
        etfp_pkg::t_seed seed;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        seed = data;
        case (idx)
            etfp_pkg::CFG_SEED_REAL: seed_re_q20 = longint'(seed);
            etfp_pkg::CFG_SEED_IMAG: seed_im_q20 = longint'(seed);
            etfp_pkg::CFG_BLUE_GAIN: blue_gain_reg = int'(data[etfp_pkg::GAIN_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input etfp_pkg::t_pix px, input etfp_pkg::t_pix py);
        int gap;
        gap = src_idle_on ? random_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_pixels.push_back(fractal_color(px, py));
    endtask

    task automatic finish_burst();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_random_settings();
        finish_burst();
        write_register(etfp_pkg::CFG_SEED_REAL, random_seed());
        write_register(etfp_pkg::CFG_SEED_IMAG, random_seed());
        write_register(etfp_pkg::CFG_BLUE_GAIN, random_gain_word());
    endtask

    task automatic test_directed_extremes();
        send_pixel(0, 0);
        send_pixel(599, 599);
        send_pixel(0, 599);
        send_pixel(599, 0);
        send_pixel(480, 300);
        send_pixel(341, 682);
        send_pixel(682, 341);
        send_pixel(600, 600);
        send_pixel(1023, 1023);
        finish_burst();
        write_register(etfp_pkg::CFG_SEED_REAL, 22'sd2097151);
        write_register(etfp_pkg::CFG_SEED_IMAG, 22'h200000);
        write_register(etfp_pkg::CFG_BLUE_GAIN, 22'd256);
        send_pixel(300, 300);
        send_pixel(0, 0);
        finish_burst();
        write_register(etfp_pkg::CFG_SEED_REAL, 22'd0);
        write_register(etfp_pkg::CFG_SEED_IMAG, 22'd0);
        write_register(etfp_pkg::CFG_BLUE_GAIN, 22'h3FFFFF);
        send_pixel(0, 300);
        send_pixel(300, 300);
        send_pixel(420, 420);
        send_pixel(150, 450);
        send_pixel(90, 90);
        finish_burst();
        write_register(etfp_pkg::CFG_BLUE_GAIN, 22'h3FFE00);
        write_register(CFG_SPARE, 22'h2AAAAA);
        send_pixel(150, 450);
        send_pixel(90, 90);
        send_pixel(511, 512);
    endtask

    task automatic test_random_settings();
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        repeat (4) begin
            load_random_settings();
            repeat (70) send_pixel(random_pixel(), random_pixel());
        end
    endtask

    task automatic test_without_idling();
        load_random_settings();
        @(negedge i_clk);
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        while (i_stall) @(negedge i_clk);
        repeat (40) send_pixel(random_pixel(), random_pixel());
    endtask

    task automatic test_output_hold();
        load_random_settings();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b1;
        hold_left = 200;
        repeat (80) send_pixel(random_pixel(), random_pixel());
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left = random_gap();
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_pixel_color want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d", o_out_x, o_out_y));
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_x !== want.x) begin
                    report_mismatch($sformatf("out_x got %0d expected %0d", o_out_x, want.x));
                end
                if (o_out_y !== want.y) begin
                    report_mismatch($sformatf("out_y got %0d expected %0d", o_out_y, want.y));
                end
                if (o_red !== want.red) begin
                    report_mismatch($sformatf("red at (%0d,%0d) got %0d expected %0d",
                                              want.x, want.y, o_red, want.red));
                end
                if (o_blue !== want.blue) begin
                    report_mismatch($sformatf("blue at (%0d,%0d) got %0d expected %0d",
                                              want.x, want.y, o_blue, want.blue));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        seed_re_q20 = longint'(etfp_pkg::SEED_RESET);
        seed_im_q20 = longint'(etfp_pkg::SEED_RESET);
        blue_gain_reg = etfp_pkg::GAIN_RESET;
        mismatch_count = 0;
        quiet_cycles = 0;
        hold_left = 0;
        stall_left = 0;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_random_settings();
        test_without_idling();
        test_output_hold();

        finish_burst();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/etfp_pkg.sv
rtl/escape_time_fractal_pixel.sv
tb/sv/escape_time_fractal_pixel_tb.sv
